// File: rtl/sha1_pkg.sv
package sha1_pkg;

  localparam int WORD_W       = 32;
  localparam int COUNT_W      = 3;
  localparam int INDEX_W      = 3;
  localparam int LEN_W        = 64;
  localparam int FILL_W       = 6;
  localparam int ROUND_W      = 7;
  localparam int NUM_CHAIN    = 5;
  localparam int WINDOW_WORDS = 16;
  localparam int ROUNDS       = 80;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t INIT_HASH [NUM_CHAIN] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  localparam logic [COUNT_W-1:0] MAX_BYTES  = 3'd4;
  localparam logic [INDEX_W-1:0] LAST_INDEX = 3'(NUM_CHAIN - 1);
  localparam logic [FILL_W-1:0]  LEN_OFFSET = 6'd56;

  typedef enum logic [1:0] {
    GRP_CH,
    GRP_PAR1,
    GRP_MAJ,
    GRP_PAR2
  } round_grp_t;

  function automatic round_grp_t round_group(input logic [ROUND_W-1:0] round);
    round_grp_t grp;
    if (round < 7'd20) begin
      grp = GRP_CH;
    end else if (round < 7'd40) begin
      grp = GRP_PAR1;
    end else if (round < 7'd60) begin
      grp = GRP_MAJ;
    end else begin
      grp = GRP_PAR2;
    end
    return grp;
  endfunction

  function automatic word_t round_const(input round_grp_t grp);
    word_t k;
    case (grp)
      GRP_CH:   k = 32'h5A82_7999;
      GRP_PAR1: k = 32'h6ED9_EBA1;
      GRP_MAJ:  k = 32'h8F1B_BCDC;
      GRP_PAR2: k = 32'hCA62_C1D6;
      default:  k = 32'h5A82_7999;
    endcase
    return k;
  endfunction

  function automatic word_t round_fn(input round_grp_t grp, input word_t b, input word_t c,
                                     input word_t d);
    word_t f;
    case (grp)
      GRP_CH:  f = (b & c) | (~b & d);
      GRP_MAJ: f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// File: rtl/sha1_in_if.sv
interface sha1_in_if;
  logic                             valid;
  logic                             ready;
  logic [sha1_pkg::WORD_W-1:0]      data_word;
  logic [sha1_pkg::COUNT_W-1:0]     byte_count;
  logic                             last_word;

  modport source (output valid, output data_word, output byte_count, output last_word,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input last_word,
                output ready);
endinterface

// File: rtl/sha1_out_if.sv
interface sha1_out_if;
  logic                             valid;
  logic                             ready;
  logic [sha1_pkg::WORD_W-1:0]      digest_word;
  logic [sha1_pkg::INDEX_W-1:0]     word_index;
  logic                             last_digest;

  modport source (output valid, output digest_word, output word_index, output last_digest,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_digest,
                output ready);
endinterface

// File: rtl/sha1_message_digest_unit.sv
// SHA-1 digest of a byte message.
// msg carries big-endian words with a count of valid left-aligned bytes (1..4,
// higher counts saturate to four, zero adds nothing) and a last-word flag.
// Bytes pack contiguously into 64-byte blocks, so short words may appear anywhere.
// dig returns the five digest words h0..h4 in order, word_index 0..4, with
// last_digest on h4; no result comes out for a word without the last flag.
// Timing: a word is taken while msg is ready. A word that completes a block starts
// the compression: 80 rounds on the one round adder, then the chain update, and
// only then is msg ready again. After a last word the padding adds the marker,
// zero fill and length, with one or two more compressions, then the five digest
// words at one per cycle when dig is ready.
// msg.ready is low for the whole of that work; one item is in flight at a time.
// If dig stalls, the current digest word holds until it is taken.
// Reset restores the initial hash value and clears length and fill; the state
// returns to the same values after the fifth digest word is taken.
module sha1_message_digest_unit (
  input  logic           clk,
  input  logic           rst,
  sha1_in_if.sink        msg,
  sha1_out_if.source     dig
);

  typedef enum logic [2:0] {
    IDLE,
    COMPRESS,
    FINISH,
    PAD_ONE,
    PAD_ZERO,
    LEN_HI,
    LEN_LO,
    EMIT
  } state_t;

  state_t state;
  state_t resume;

  sha1_pkg::word_t chain  [sha1_pkg::NUM_CHAIN];
  sha1_pkg::word_t vars   [sha1_pkg::NUM_CHAIN];
  sha1_pkg::word_t window [sha1_pkg::WINDOW_WORDS];

  logic [sha1_pkg::LEN_W-1:0]   bit_length;
  logic [sha1_pkg::FILL_W-1:0]  fill;
  logic [23:0]                  partial;
  logic [sha1_pkg::ROUND_W-1:0] round;
  logic [sha1_pkg::INDEX_W-1:0] emit_idx;

  // byte packing
  sha1_pkg::word_t               abs_data;
  logic [sha1_pkg::COUNT_W-1:0]  abs_cnt;
  logic                          abs_en;
  logic [sha1_pkg::COUNT_W-1:0]  in_cnt;
  logic [55:0]                   merged;
  logic [55:0]                   aligned;
  logic [2:0]                    total;
  logic [1:0]                    extra;
  logic                          word_done;
  sha1_pkg::word_t               done_word;
  logic [23:0]                   partial_next;
  logic [sha1_pkg::FILL_W:0]     fill_sum;
  logic                          block_full;

  assign in_cnt = (msg.byte_count > sha1_pkg::MAX_BYTES) ? sha1_pkg::MAX_BYTES
                                                          : msg.byte_count;

  always_comb begin
    abs_data = '0;
    abs_cnt  = '0;
    abs_en   = 1'b0;
    case (state)
      IDLE: begin
        abs_data = msg.data_word;
        abs_cnt  = in_cnt;
        abs_en   = msg.valid;
      end
      PAD_ONE: begin
        abs_data = 32'h8000_0000;
        abs_cnt  = 3'd1;
        abs_en   = 1'b1;
      end
      PAD_ZERO: begin
        abs_cnt  = sha1_pkg::MAX_BYTES - {1'b0, fill[1:0]};
        abs_en   = (fill != sha1_pkg::LEN_OFFSET);
      end
      LEN_HI: begin
        abs_data = bit_length[63:32];
        abs_cnt  = sha1_pkg::MAX_BYTES;
        abs_en   = 1'b1;
      end
      LEN_LO: begin
        abs_data = bit_length[31:0];
        abs_cnt  = sha1_pkg::MAX_BYTES;
        abs_en   = 1'b1;
      end
      default: begin
        abs_en   = 1'b0;
      end
    endcase
  end

  always_comb begin
    merged       = ({32'b0, partial} << {abs_cnt, 3'b000})
                 | ({24'b0, abs_data} >> (6'd32 - {abs_cnt, 3'b000}));
    total        = {1'b0, fill[1:0]} + abs_cnt;
    word_done    = total[2];
    extra        = total[1:0];
    aligned      = merged >> {extra, 3'b000};
    done_word    = aligned[31:0];
    partial_next = word_done ? (merged[23:0] & ~(24'hFF_FFFF << {extra, 3'b000}))
                             : merged[23:0];
    fill_sum     = {1'b0, fill} + {4'b0, abs_cnt};
    block_full   = fill_sum[sha1_pkg::FILL_W];
  end

  // round datapath
  sha1_pkg::round_grp_t grp;
  sha1_pkg::word_t      f_val;
  sha1_pkg::word_t      temp;
  sha1_pkg::word_t      w_mix;
  sha1_pkg::word_t      w_new;

  always_comb begin
    grp   = sha1_pkg::round_group(round);
    f_val = sha1_pkg::round_fn(grp, vars[1], vars[2], vars[3]);
    temp  = {vars[0][26:0], vars[0][31:27]} + f_val + vars[4]
          + sha1_pkg::round_const(grp) + window[0];
    w_mix = window[13] ^ window[8] ^ window[2] ^ window[0];
    w_new = {w_mix[30:0], w_mix[31]};
  end

  // message schedule window, shifted once per round
  always_ff @(posedge clk) begin
    if (abs_en && word_done) begin
      window[fill[5:2]] <= done_word;
    end else if (state == COMPRESS) begin
      for (int i = 0; i < sha1_pkg::WINDOW_WORDS - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[sha1_pkg::WINDOW_WORDS-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      resume     <= IDLE;
      bit_length <= '0;
      fill       <= '0;
      partial    <= '0;
      round      <= '0;
      emit_idx   <= '0;
      for (int i = 0; i < sha1_pkg::NUM_CHAIN; i++) begin
        chain[i] <= sha1_pkg::INIT_HASH[i];
        vars[i]  <= '0;
      end
    end else begin
      if (abs_en) begin
        partial <= partial_next;
        fill    <= fill_sum[sha1_pkg::FILL_W-1:0];
      end
      if (abs_en && block_full) begin
        round <= '0;
        for (int i = 0; i < sha1_pkg::NUM_CHAIN; i++) begin
          vars[i] <= chain[i];
        end
      end
      case (state)
        IDLE: begin
          if (msg.valid) begin
            bit_length <= bit_length + {58'b0, abs_cnt, 3'b000};
            if (block_full) begin
              state  <= COMPRESS;
              resume <= msg.last_word ? PAD_ONE : IDLE;
            end else if (msg.last_word) begin
              state  <= PAD_ONE;
            end
          end
        end
        COMPRESS: begin
          vars[4] <= vars[3];
          vars[3] <= vars[2];
          vars[2] <= {vars[1][1:0], vars[1][31:2]};
          vars[1] <= vars[0];
          vars[0] <= temp;
          round   <= round + 7'd1;
          if (round == 7'(sha1_pkg::ROUNDS - 1)) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          for (int i = 0; i < sha1_pkg::NUM_CHAIN; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          state <= resume;
        end
        PAD_ONE: begin
          state  <= block_full ? COMPRESS : PAD_ZERO;
          resume <= PAD_ZERO;
        end
        PAD_ZERO: begin
          if (fill == sha1_pkg::LEN_OFFSET) begin
            state <= LEN_HI;
          end else if (block_full) begin
            state  <= COMPRESS;
            resume <= PAD_ZERO;
          end
        end
        LEN_HI: begin
          state <= LEN_LO;
        end
        LEN_LO: begin
          state  <= COMPRESS;
          resume <= EMIT;
        end
        EMIT: begin
          if (dig.ready) begin
            if (emit_idx == sha1_pkg::LAST_INDEX) begin
              state      <= IDLE;
              emit_idx   <= '0;
              bit_length <= '0;
              fill       <= '0;
              partial    <= '0;
              for (int i = 0; i < sha1_pkg::NUM_CHAIN; i++) begin
                chain[i] <= sha1_pkg::INIT_HASH[i];
                vars[i]  <= '0;
              end
            end else begin
              emit_idx <= emit_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign msg.ready       = (state == IDLE);
  assign dig.valid       = (state == EMIT);
  assign dig.digest_word = chain[emit_idx];
  assign dig.word_index  = emit_idx;
  assign dig.last_digest = (emit_idx == sha1_pkg::LAST_INDEX);

endmodule

// File: rtl/sha1_mdu_chk.sv
module sha1_mdu_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          msg_ready,
  input logic                          dig_valid,
  input logic                          dig_ready,
  input logic [sha1_pkg::WORD_W-1:0]   digest_word,
  input logic [sha1_pkg::INDEX_W-1:0]  word_index,
  input logic                          last_digest
);

  // never take an item while the digest is going out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && dig_valid))
    else $error("input ready while digest words are pending");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> (last_digest == (word_index == sha1_pkg::LAST_INDEX)))
    else $error("last_digest does not match word_index");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_ready && !last_digest) |=>
      (dig_valid && (word_index == $past(word_index) + 3'd1)))
    else $error("digest words out of order");

  a_ready_after: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_ready && last_digest) |=> (msg_ready && !dig_valid))
    else $error("not ready for a new message after the digest");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && !dig_ready) |=> (dig_valid && $stable(digest_word)))
    else $error("stalled digest word changed");

endmodule

bind sha1_message_digest_unit sha1_mdu_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .msg_ready   (msg.ready),
  .dig_valid   (dig.valid),
  .dig_ready   (dig.ready),
  .digest_word (dig.digest_word),
  .word_index  (dig.word_index),
  .last_digest (dig.last_digest)
);
